>>> design/jet_pkg.sv
// Shared types, constants and helper functions of the Julia escape-time pixel block.
// Depends on nothing; every other file of the block imports it.
package jet_pkg;

   // Field and register widths.
   localparam int unsigned PIX_W   = 10;
   localparam int unsigned SIZE_W  = 11;
   localparam int unsigned ZOOM_W  = 10;
   localparam int unsigned Q_W     = 32;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned CSR_IDX_W = 3;

   // Mapping divider: the numerator magnitude is at most 6*1023 times 2^28.
   localparam int unsigned Q_FRAC  = 28;
   localparam int unsigned MAG_W   = 13;
   localparam int unsigned NUM_W   = MAG_W + Q_FRAC;
   localparam int unsigned DEN_W   = ZOOM_W + SIZE_W;
   localparam int unsigned REM_W   = DEN_W + 1;
   localparam int unsigned BITCNT_W = $clog2(NUM_W);
   localparam int unsigned OFF_W   = NUM_W + 2;
   localparam int unsigned WIDE_W  = 48;

   // Squared magnitude of 4 in Q8.56.
   localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

   localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE = 48'sh0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE = -48'sh0000_8000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_C_RE         = 3'd0,
      CSR_C_IM         = 3'd1,
      CSR_CENTER_RE    = 3'd2,
      CSR_CENTER_IM    = 3'd3,
      CSR_ZOOM_HALVES  = 3'd4,
      CSR_IMAGE_WIDTH  = 3'd5,
      CSR_IMAGE_HEIGHT = 3'd6
   } jet_csr_index_type;

   typedef struct packed {
      logic signed [Q_W-1:0] c_re;
      logic signed [Q_W-1:0] c_im;
      logic signed [Q_W-1:0] center_re;
      logic signed [Q_W-1:0] center_im;
      logic [ZOOM_W-1:0]     zoom_halves;
      logic [SIZE_W-1:0]     image_width;
      logic [SIZE_W-1:0]     image_height;
   } jet_cfg_type;

   // One mapped start point, as it travels through the queue.
   typedef struct packed {
      logic signed [Q_W-1:0] re;
      logic signed [Q_W-1:0] im;
   } jet_point_type;

   typedef enum logic [2:0] {
      FRONT_IDLE,
      FRONT_LOAD,
      FRONT_DIV,
      FRONT_STORE,
      FRONT_PUSH
   } jet_front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_EVAL,
      BACK_DONE
   } jet_back_state_type;

   // Clamp a wide signed value to the Q4.28 range.
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > Q_MAX_WIDE) begin
         r = Q_MAX_WIDE[Q_W-1:0];
      end else if (v < Q_MIN_WIDE) begin
         r = Q_MIN_WIDE[Q_W-1:0];
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/jet_if.sv
// Channel interfaces of the Julia escape-time pixel block: pixel request,
// result and register write. Depends on jet_pkg.
interface jet_req_if import jet_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface jet_rsp_if import jet_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   logic               escaped;
   modport source (output valid, output iteration_count, output escaped, input ready);
   modport sink (input valid, input iteration_count, input escaped, output ready);
endinterface

interface jet_csr_if import jet_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [Q_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/julia_escape_time_pixel.sv
// Julia escape-time evaluator for one pixel per request word. A front end maps
// the pixel to a Q4.28 start point with a bit-serial divider, one axis after the
// other; a two-word queue passes the point to the back end, which runs each
// iteration as a multiply, then escape test and update, for at most MAX_ITER
// iterations. The front end can map the next pixel while the back end iterates.
// Registers are written through the csr channel; the user must write them only
// while no pixel is in work, as the block itself does not enforce it.
// Depends on jet_pkg, jet_if, jet_front, jet_queue and jet_back.
module julia_escape_time_pixel import jet_pkg::*; #(
   parameter int unsigned MAX_ITER = 64
) (
   input  logic       clock,
   input  logic       reset,
   jet_req_if.sink    req_chan,
   jet_rsp_if.source  rsp_chan,
   jet_csr_if.sink    csr_chan
);

   jet_cfg_type   cfg_ff, cfg_in;
   logic          fq_valid, fq_ready, qb_valid, qb_ready;
   jet_point_type fq_point, qb_point;

   assign csr_chan.ready = 1'b1;

   // Register writes; indexes past the list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_C_RE:         cfg_in.c_re         = csr_chan.data;
            CSR_C_IM:         cfg_in.c_im         = csr_chan.data;
            CSR_CENTER_RE:    cfg_in.center_re    = csr_chan.data;
            CSR_CENTER_IM:    cfg_in.center_im    = csr_chan.data;
            CSR_ZOOM_HALVES:  cfg_in.zoom_halves  = csr_chan.data[ZOOM_W-1:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_chan.data[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_chan.data[SIZE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_re         <= '0;
         cfg_ff.c_im         <= '0;
         cfg_ff.center_re    <= '0;
         cfg_ff.center_im    <= '0;
         cfg_ff.zoom_halves  <= ZOOM_W'(2);
         cfg_ff.image_width  <= SIZE_W'(1024);
         cfg_ff.image_height <= SIZE_W'(768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jet_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req         (req_chan),
      .point_valid (fq_valid),
      .point_ready (fq_ready),
      .point       (fq_point)
   );

   jet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_point (fq_point),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_point  (qb_point)
   );

   jet_back #(
      .MAX_ITER (MAX_ITER)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .point_valid (qb_valid),
      .point_ready (qb_ready),
      .point       (qb_point),
      .rsp         (rsp_chan)
   );

endmodule

>>> design/jet_front.sv
// Front end: accepts a pixel word and maps it to a Q4.28 start point with a
// bit-serial restoring divider, one quotient bit per cycle. Depends on jet_pkg.
module jet_front import jet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  jet_cfg_type   cfg,
   jet_req_if.sink       req,
   output logic          point_valid,
   input  logic          point_ready,
   output jet_point_type point
);

   jet_front_state_type state_ff, state_in;
   logic                  axis_ff, axis_in;
   logic [PIX_W-1:0]      px_ff, px_in, py_ff, py_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [BITCNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [Q_W-1:0] re_ff, re_in, im_ff, im_in;

   logic [PIX_W-1:0]      pix;
   logic [SIZE_W-1:0]     size;
   logic [ZOOM_W-1:0]     zoom_eff;
   logic [SIZE_W-1:0]     size_eff;
   logic signed [PIX_W:0] dx;
   logic [PIX_W-1:0]      dx_abs;
   logic [MAG_W-1:0]      mag;
   logic [REM_W-1:0]      rem_shift;
   logic                  q_bit;
   logic signed [OFF_W-1:0]  off;
   logic signed [WIDE_W-1:0] sum;
   logic signed [Q_W-1:0]    center;
   logic signed [Q_W-1:0]    mapped;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:  if (req.valid) state_in = FRONT_LOAD;
         FRONT_LOAD:  state_in = FRONT_DIV;
         FRONT_DIV:   if (cnt_ff == '0) state_in = FRONT_STORE;
         FRONT_STORE: state_in = axis_ff ? FRONT_PUSH : FRONT_LOAD;
         FRONT_PUSH:  if (point_ready) state_in = FRONT_IDLE;
         default:     state_in = FRONT_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req.ready   = 1'b0;
      point_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: req.ready   = 1'b1;
         FRONT_PUSH: point_valid = 1'b1;
         default: begin
            req.ready   = 1'b0;
            point_valid = 1'b0;
         end
      endcase
   end

   assign point.re = re_ff;
   assign point.im = im_ff;

   // Axis operands: the pixel offset from the floored half size, and the divisor.
   always_comb begin
      pix      = axis_ff ? py_ff : px_ff;
      size     = axis_ff ? cfg.image_height : cfg.image_width;
      center   = axis_ff ? cfg.center_im : cfg.center_re;
      zoom_eff = (cfg.zoom_halves == '0) ? ZOOM_W'(1) : cfg.zoom_halves;
      size_eff = (size == '0) ? SIZE_W'(1) : size;
      dx       = $signed({1'b0, pix}) - $signed({1'b0, size[SIZE_W-1:1]});
      dx_abs   = dx[PIX_W] ? PIX_W'(-dx) : dx[PIX_W-1:0];
      // Scale by 4 on the imaginary axis and by 6 on the real axis.
      mag      = axis_ff ? (MAG_W'(dx_abs) << 2)
                         : ((MAG_W'(dx_abs) << 2) + (MAG_W'(dx_abs) << 1));
   end

   // One restoring division step.
   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
      q_bit     = (rem_shift >= {1'b0, den_ff});
   end

   // Signed quotient plus center, clamped to Q4.28.
   always_comb begin
      off    = neg_ff ? -$signed({2'b00, num_ff}) : $signed({2'b00, num_ff});
      sum    = WIDE_W'(off) + WIDE_W'(center);
      mapped = sat_q(sum);
   end

   // Datapath next values.
   always_comb begin
      axis_in = axis_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      re_in   = re_ff;
      im_in   = im_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (req.valid) begin
               px_in   = req.pixel_x;
               py_in   = req.pixel_y;
               axis_in = 1'b0;
            end
         end
         FRONT_LOAD: begin
            num_in = {mag, {Q_FRAC{1'b0}}};
            rem_in = '0;
            den_in = DEN_W'(zoom_eff * size_eff);
            neg_in = dx[PIX_W];
            cnt_in = BITCNT_W'(NUM_W - 1);
         end
         FRONT_DIV: begin
            rem_in = q_bit ? (rem_shift - {1'b0, den_ff}) : rem_shift;
            num_in = {num_ff[NUM_W-2:0], q_bit};
            cnt_in = cnt_ff - 1'b1;
         end
         FRONT_STORE: begin
            if (axis_ff) begin
               im_in = mapped;
            end else begin
               re_in   = mapped;
               axis_in = 1'b1;
            end
         end
         default: begin
            axis_in = axis_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      axis_ff <= axis_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      re_ff   <= re_in;
      im_ff   <= im_in;
   end

endmodule

>>> design/jet_queue.sv
// Two-entry queue of mapped start points between the front and back ends.
// Depends on jet_pkg.
module jet_queue import jet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  jet_point_type push_point,
   output logic          pop_valid,
   input  logic          pop_ready,
   output jet_point_type pop_point
);

   logic [1:0]    count_ff, count_in;
   jet_point_type head_ff, head_in, tail_ff, tail_in;
   logic          push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_point  = head_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // The head is always the oldest word; a pop moves the tail forward.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
         if (count_ff == 2'd0) begin
            head_in = push_point;
         end else begin
            tail_in = push_point;
         end
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
         head_in  = tail_ff;
      end else if (pop && push) begin
         if (count_ff == 2'd1) begin
            head_in = push_point;
         end else begin
            head_in = tail_ff;
            tail_in = push_point;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count beyond its depth");
   a_pop_tracks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue count not lowered by a pop");
`endif

endmodule

>>> design/jet_back.sv
// Back end: iterates z = z*z + c on one start point, each step a multiply and
// then the escape test and update, and holds the result word.
// Depends on jet_pkg and jet_if.
module jet_back import jet_pkg::*; #(
   parameter int unsigned MAX_ITER = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  jet_cfg_type   cfg,
   input  logic          point_valid,
   output logic          point_ready,
   input  jet_point_type point,
   jet_rsp_if.source     rsp
);

   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_ITER);

   jet_back_state_type state_ff, state_in;
   logic signed [Q_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [63:0]    rr_ff, ii_ff, ri_ff;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  esc_ff, esc_in;
   logic                  out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic                  out_esc_ff, out_esc_in;

   logic                  out_free;
   logic                  out_load;
   logic                  is_out;
   logic signed [63:0]    diff;
   logic signed [WIDE_W-1:0] nre, nim;

   assign out_free = !out_valid_ff || rsp.ready;

   // Escape test and next point from the registered products.
   always_comb begin
      is_out = ($unsigned(rr_ff) + $unsigned(ii_ff)) >= ESCAPE_LIMIT;
      diff   = rr_ff - ii_ff;
      nre    = WIDE_W'(diff >>> Q_FRAC) + WIDE_W'(cfg.c_re);
      nim    = WIDE_W'(ri_ff >>> (Q_FRAC - 1)) + WIDE_W'(cfg.c_im);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (point_valid) state_in = BACK_MUL;
         BACK_MUL:  state_in = BACK_EVAL;
         BACK_EVAL: state_in = (is_out || count_ff == MaxCount) ? BACK_DONE : BACK_MUL;
         BACK_DONE: if (out_free) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      point_ready = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         BACK_IDLE: point_ready = 1'b1;
         BACK_DONE: out_load    = out_free;
         default: begin
            point_ready = 1'b0;
            out_load    = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      re_in    = re_ff;
      im_in    = im_ff;
      count_in = count_ff;
      esc_in   = esc_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (point_valid) begin
               re_in    = point.re;
               im_in    = point.im;
               count_in = '0;
            end
         end
         BACK_EVAL: begin
            esc_in = is_out;
            if (!is_out && count_ff != MaxCount) begin
               re_in    = sat_q(nre);
               im_in    = sat_q(nim);
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            esc_in = esc_ff;
         end
      endcase
   end

   // Output register: loaded when free, cleared when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_count_in = out_count_ff;
      out_esc_in   = out_esc_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_count_in = count_ff;
         out_esc_in   = esc_ff;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.iteration_count = out_count_ff;
   assign rsp.escaped         = out_esc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
      re_ff        <= re_in;
      im_ff        <= im_in;
      esc_ff       <= esc_in;
      out_count_ff <= out_count_in;
      out_esc_ff   <= out_esc_in;
      // Products of the current point; each feeds only the escape test and update.
      rr_ff        <= re_ff * re_ff;
      ii_ff        <= im_ff * im_ff;
      ri_ff        <= re_ff * im_ff;
   end

`ifndef SYNTHESIS
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount) else $error("iteration count beyond limit");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp.ready))
      else $error("result word overwritten before it was taken");
   a_early_escape: assert property (@(posedge clock) disable iff (reset)
      (out_load && count_ff != MaxCount) |-> esc_ff)
      else $error("iteration stopped early without escape");
`endif

endmodule
